### design/assert_macros.svh
// Assertion macros used by the checker module of the polygon offset block.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define POE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("poe checker: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define POE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("poe checker: assertion failed");

`endif

### design/poe_pkg.sv
// Types, constants and helper functions of the polygon offset block.
// No dependencies; the divider, square root, front, back, top and checker refer to it by scoped names.
`default_nettype none

package poe_pkg;

    localparam int COORD_W = 24;
    localparam int DIST_W = 8;
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_STEPS = 48;
    localparam int SQRT_IN_W = 52;
    localparam int SQRT_OUT_W = 26;
    localparam int SQRT_STEPS = 26;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_DEGEN    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic signed [49:0] CMAX = 50'sd8388607;
    localparam logic signed [49:0] CMIN = -50'sd8388608;

    // While the larger magnitude is below this, both are doubled before the square root.
    localparam logic [24:0] NORM_MIN = 25'd8388608;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      last_out;
        logic [1:0]                status;
    } poe_result_t;

    typedef enum logic [4:0] {
        B_IDLE,
        B_RDA,
        B_RDB,
        B_RDW,
        B_U_START,
        B_U_NORM,
        B_U_SQ1,
        B_U_SQ2,
        B_U_SQRT,
        B_U_DIVX,
        B_U_DIVY,
        B_PREV_DONE,
        B_CUR_DONE,
        B_O_DONE,
        B_DOT1,
        B_DOT2,
        B_OFS_X,
        B_OFS_Y,
        B_EMIT
    } poe_bstate_t;

    typedef enum logic [1:0] {
        RET_PREV,
        RET_CUR,
        RET_O
    } poe_ret_t;

    function automatic logic signed [COORD_W-1:0] sat24(input logic signed [49:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > CMAX)
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < CMIN)
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/poe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module poe_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/poe_fifo.sv
// Small register queue used between the front and back and on the result side.
// No dependencies.
`default_nettype none

module poe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             rd,
    output logic      [WIDTH-1:0] dout,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [NW-1:0]    cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    always_comb
    begin
        full  = (cnt_reg == NW'(DEPTH));
        empty = (cnt_reg == '0);
        dout  = data_reg[rptr_reg];
        do_wr = wr && !full;
        do_rd = rd && !empty;
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

### design/poe_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on poe_pkg for the operand widths and step count.
`default_nettype none

module poe_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [poe_pkg::DIV_NUM_W-1:0]   num,
    input  wire logic [poe_pkg::DIV_DEN_W-1:0]   den,
    output logic                                 done,
    output logic      [poe_pkg::DIV_NUM_W-1:0]   quo
);

    localparam int NW = poe_pkg::DIV_NUM_W;
    localparam int DW = poe_pkg::DIV_DEN_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [NW-1:0] num_reg, num_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW:0]   rem_w;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        rem_w     = {rem_reg, num_reg[NW-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NW-2:0], 1'b0};
            if (rem_w >= {1'b0, den_reg})
            begin
                rem_next = DW'(rem_w - {1'b0, den_reg});
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_w[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            if (cnt_reg == 6'(poe_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        done = done_reg;
        quo  = quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

endmodule

`default_nettype wire

### design/poe_sqrt.sv
// Floor integer square root, one result bit per cycle.
// Depends on poe_pkg for the operand widths and step count.
`default_nettype none

module poe_sqrt (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [poe_pkg::SQRT_IN_W-1:0]    rad,
    output logic                                  done,
    output logic      [poe_pkg::SQRT_OUT_W-1:0]   root
);

    localparam int IW = poe_pkg::SQRT_IN_W;
    localparam int OW = poe_pkg::SQRT_OUT_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [IW-1:0] rad_reg, rad_next;
    logic [OW-1:0] root_reg, root_next;
    logic [OW+1:0] rem_reg, rem_next;
    logic [OW+3:0] rem_w;
    logic [OW+3:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        rem_w     = {rem_reg, rad_reg[IW-1:IW-2]};
        trial     = {2'b00, root_reg, 2'b01};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = rad;
            root_next = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[IW-3:0], 2'b00};
            if (rem_w >= trial)
            begin
                rem_next  = (OW + 2)'(rem_w - trial);
                root_next = {root_reg[OW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_w[OW+1:0];
                root_next = {root_reg[OW-2:0], 1'b0};
            end
            if (cnt_reg == 5'(poe_pkg::SQRT_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        done = done_reg;
        root = root_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

endmodule

`default_nettype wire

### design/poe_front.sv
// Front end: takes vertex requests, writes up to MAX_POINTS of them to the vertex store
// and queues one job per polygon, with an overflow flag. Depends on poe_pkg.
`default_nettype none

module poe_front #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   push,
    input  wire logic signed [poe_pkg::COORD_W-1:0]     point_x,
    input  wire logic signed [poe_pkg::COORD_W-1:0]     point_y,
    input  wire logic                                   last_point,
    output logic                                        full,
    input  wire logic                                   job_full,
    output logic                                        job_push,
    output logic [$clog2(MAX_POINTS+1):0]               job_data,
    output logic                                        ram_we,
    output logic [$clog2(MAX_POINTS)-1:0]               ram_waddr,
    output logic [2*poe_pkg::COORD_W-1:0]               ram_wdata,
    input  wire logic                                   done
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          busy_reg, busy_next;
    logic          acc, stored;
    logic [CW-1:0] cnt_inc;
    logic          ovf_inc;

    always_comb
    begin
        full      = busy_reg || job_full;
        acc       = push && !full;
        stored    = (count_reg < CW'(MAX_POINTS));
        ram_we    = acc && stored;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata = {point_x, point_y};
        cnt_inc   = stored ? count_reg + 1'b1 : count_reg;
        ovf_inc   = ovf_reg || !stored;
        job_push  = 1'b0;
        job_data  = {ovf_inc, cnt_inc};
        count_next = count_reg;
        ovf_next   = ovf_reg;
        busy_next  = busy_reg;
        if (acc)
        begin
            if (last_point)
            begin
                // The store stays owned by the back end until it reports done.
                job_push   = 1'b1;
                count_next = '0;
                ovf_next   = 1'b0;
                busy_next  = 1'b1;
            end
            else
            begin
                count_next = cnt_inc;
                ovf_next   = ovf_inc;
            end
        end
        if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

`default_nettype wire

### design/poe_back.sv
// Back end: for each stored vertex computes edge unit vectors, the miter
// direction and the offset, on one shared divider and square root unit.
// Depends on poe_pkg, poe_div and poe_sqrt.
`default_nettype none

module poe_back #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                job_empty,
    input  wire logic [$clog2(MAX_POINTS+1):0]       job_data,
    output logic                                     job_pop,
    output logic [$clog2(MAX_POINTS)-1:0]            ram_raddr,
    input  wire logic [2*poe_pkg::COORD_W-1:0]       ram_rdata,
    input  wire logic [poe_pkg::DIST_W-1:0]          offset_distance,
    input  wire logic                                res_full,
    output logic                                     res_push,
    output poe_pkg::poe_result_t                     res_data,
    output logic                                     done
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    poe_pkg::poe_bstate_t state_reg, state_next;
    poe_pkg::poe_ret_t    ret_reg, ret_next;

    logic [CW-1:0] n_reg, n_next;
    logic          ovf_reg, ovf_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] a_reg, a_next;
    logic [AW-1:0] b_reg, b_next;
    logic          launched_reg, launched_next;

    logic signed [23:0] pa_x_reg, pa_x_next, pa_y_reg, pa_y_next;
    logic signed [25:0] vin_x_reg, vin_x_next, vin_y_reg, vin_y_next;
    logic               sx_reg, sx_next, sy_reg, sy_next;
    logic [24:0]        ax_reg, ax_next, ay_reg, ay_next;
    logic [51:0]        sq_reg, sq_next;
    logic [25:0]        m_reg, m_next;
    logic [16:0]        qx_reg, qx_next;
    logic               uok_reg, uok_next;
    logic signed [16:0] ux_reg, ux_next, uy_reg, uy_next;
    logic               prev_ok_reg, prev_ok_next;
    logic signed [16:0] prev_ux_reg, prev_ux_next, prev_uy_reg, prev_uy_next;
    logic               cur_ok_reg, cur_ok_next;
    logic signed [16:0] cur_ux_reg, cur_ux_next, cur_uy_reg, cur_uy_next;
    logic signed [16:0] ox_reg, ox_next, oy_reg, oy_next;
    logic signed [34:0] dot_reg, dot_next;
    logic signed [23:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [1:0]         st_reg, st_next;

    logic               div_start, div_done;
    logic [47:0]        div_num, div_quo;
    logic [31:0]        div_den;
    logic               sqrt_start, sqrt_done;
    logic [25:0]        sqrt_root;

    logic [24:0]        sq_op;
    logic [49:0]        sq_prod;
    logic signed [16:0] dm_a, dm_b;
    logic signed [33:0] dprod;
    logic signed [16:0] oc;
    logic signed [25:0] pm;
    logic [24:0]        apm;
    logic [34:0]        adot_w;
    logic [31:0]        adot;
    logic               off_neg;
    logic signed [49:0] off_val, sum_val, base_val;
    logic signed [17:0] vsum_x, vsum_y;
    logic signed [25:0] diff_x, diff_y;
    logic [24:0]        amax;
    logic [CW-1:0]      ip1, ip2;
    logic [CW-1:0]      nm1;
    logic               is_last;
    poe_pkg::poe_bstate_t ret_state;

    poe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    poe_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (sq_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // Shared datapath pieces; which operands they see depends on the state.
    always_comb
    begin
        sq_op   = (state_reg == poe_pkg::B_U_SQ1) ? ax_reg : ay_reg;
        sq_prod = sq_op * sq_op;
        dm_a    = (state_reg == poe_pkg::B_DOT1) ? cur_uy_reg : cur_ux_reg;
        dm_b    = (state_reg == poe_pkg::B_DOT1) ? ox_reg : oy_reg;
        dprod   = dm_a * dm_b;
        oc      = (state_reg == poe_pkg::B_OFS_X) ? ox_reg : oy_reg;
        pm      = oc * $signed({1'b0, offset_distance});
        apm     = pm[25] ? 25'(-pm) : 25'(pm);
        adot_w  = dot_reg[34] ? 35'(-dot_reg) : 35'(dot_reg);
        adot    = adot_w[31:0];
        off_neg = (pm[25] != dot_reg[34]);
        off_val = off_neg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
        base_val = (state_reg == poe_pkg::B_OFS_X) ? 50'(pa_x_reg) : 50'(pa_y_reg);
        sum_val = base_val + off_val;
        vsum_x  = 18'(ux_reg) + 18'(prev_ux_reg);
        vsum_y  = 18'(uy_reg) + 18'(prev_uy_reg);
        diff_x  = 26'($signed(ram_rdata[47:24])) - 26'(pa_x_reg);
        diff_y  = 26'($signed(ram_rdata[23:0])) - 26'(pa_y_reg);
        amax    = (ax_reg > ay_reg) ? ax_reg : ay_reg;
        ip1     = CW'(i_reg) + 1'b1;
        ip2     = CW'(i_reg) + 2'd2;
        nm1     = CW'(job_data[CW-1:0] - 1'b1);
        is_last = (ip1 == n_reg);

        unique case (state_reg)
            poe_pkg::B_U_DIVX:
            begin
                div_num = {8'b0, ax_reg, 15'b0} + {22'b0, m_reg[25:1]};
                div_den = {6'b0, m_reg};
            end
            poe_pkg::B_U_DIVY:
            begin
                div_num = {8'b0, ay_reg, 15'b0} + {22'b0, m_reg[25:1]};
                div_den = {6'b0, m_reg};
            end
            default:
            begin
                div_num = {apm, 23'b0} + {17'b0, adot[31:1]};
                div_den = adot;
            end
        endcase

        unique case (ret_reg)
            poe_pkg::RET_PREV: ret_state = poe_pkg::B_PREV_DONE;
            poe_pkg::RET_CUR:  ret_state = poe_pkg::B_CUR_DONE;
            poe_pkg::RET_O:    ret_state = poe_pkg::B_O_DONE;
            default:           ret_state = poe_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        n_next        = n_reg;
        ovf_next      = ovf_reg;
        i_next        = i_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        launched_next = launched_reg;
        pa_x_next     = pa_x_reg;
        pa_y_next     = pa_y_reg;
        vin_x_next    = vin_x_reg;
        vin_y_next    = vin_y_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        sq_next       = sq_reg;
        m_next        = m_reg;
        qx_next       = qx_reg;
        uok_next      = uok_reg;
        ux_next       = ux_reg;
        uy_next       = uy_reg;
        prev_ok_next  = prev_ok_reg;
        prev_ux_next  = prev_ux_reg;
        prev_uy_next  = prev_uy_reg;
        cur_ok_next   = cur_ok_reg;
        cur_ux_next   = cur_ux_reg;
        cur_uy_next   = cur_uy_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        dot_next      = dot_reg;
        out_x_next    = out_x_reg;
        out_y_next    = out_y_reg;
        st_next       = st_reg;
        job_pop       = 1'b0;
        div_start     = 1'b0;
        sqrt_start    = 1'b0;
        res_push      = 1'b0;
        done          = 1'b0;
        ram_raddr     = (state_reg == poe_pkg::B_RDA) ? a_reg : b_reg;

        res_data.out_x    = out_x_reg;
        res_data.out_y    = out_y_reg;
        res_data.last_out = is_last;
        res_data.status   = ovf_reg ? poe_pkg::STATUS_OVERFLOW : st_reg;

        unique case (state_reg)
            poe_pkg::B_IDLE:
            begin
                if (!job_empty)
                begin
                    // Start with the closing edge, from the last vertex to the first.
                    job_pop    = 1'b1;
                    n_next     = job_data[CW-1:0];
                    ovf_next   = job_data[CW];
                    i_next     = '0;
                    a_next     = nm1[AW-1:0];
                    b_next     = '0;
                    ret_next   = poe_pkg::RET_PREV;
                    state_next = poe_pkg::B_RDA;
                end
            end
            poe_pkg::B_RDA:
            begin
                state_next = poe_pkg::B_RDB;
            end
            poe_pkg::B_RDB:
            begin
                pa_x_next  = $signed(ram_rdata[47:24]);
                pa_y_next  = $signed(ram_rdata[23:0]);
                state_next = poe_pkg::B_RDW;
            end
            poe_pkg::B_RDW:
            begin
                vin_x_next = diff_x;
                vin_y_next = diff_y;
                state_next = poe_pkg::B_U_START;
            end
            poe_pkg::B_U_START:
            begin
                sx_next = vin_x_reg[25];
                sy_next = vin_y_reg[25];
                ax_next = vin_x_reg[25] ? 25'(-vin_x_reg) : 25'(vin_x_reg);
                ay_next = vin_y_reg[25] ? 25'(-vin_y_reg) : 25'(vin_y_reg);
                if (vin_x_reg == '0 && vin_y_reg == '0)
                begin
                    uok_next   = 1'b0;
                    state_next = ret_state;
                end
                else
                begin
                    state_next = poe_pkg::B_U_NORM;
                end
            end
            poe_pkg::B_U_NORM:
            begin
                if (amax < poe_pkg::NORM_MIN)
                begin
                    ax_next = {ax_reg[23:0], 1'b0};
                    ay_next = {ay_reg[23:0], 1'b0};
                end
                else
                begin
                    state_next = poe_pkg::B_U_SQ1;
                end
            end
            poe_pkg::B_U_SQ1:
            begin
                sq_next    = {2'b00, sq_prod};
                state_next = poe_pkg::B_U_SQ2;
            end
            poe_pkg::B_U_SQ2:
            begin
                sq_next    = sq_reg + {2'b00, sq_prod};
                state_next = poe_pkg::B_U_SQRT;
            end
            poe_pkg::B_U_SQRT:
            begin
                if (!launched_reg)
                begin
                    sqrt_start    = 1'b1;
                    launched_next = 1'b1;
                end
                else if (sqrt_done)
                begin
                    launched_next = 1'b0;
                    m_next        = sqrt_root;
                    state_next    = poe_pkg::B_U_DIVX;
                end
            end
            poe_pkg::B_U_DIVX:
            begin
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (div_done)
                begin
                    launched_next = 1'b0;
                    qx_next       = div_quo[16:0];
                    state_next    = poe_pkg::B_U_DIVY;
                end
            end
            poe_pkg::B_U_DIVY:
            begin
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (div_done)
                begin
                    launched_next = 1'b0;
                    ux_next  = sx_reg ? -$signed(qx_reg) : $signed(qx_reg);
                    uy_next  = sy_reg ? -$signed(div_quo[16:0]) : $signed(div_quo[16:0]);
                    uok_next = 1'b1;
                    state_next = ret_state;
                end
            end
            poe_pkg::B_PREV_DONE:
            begin
                prev_ok_next = uok_reg;
                prev_ux_next = ux_reg;
                prev_uy_next = uy_reg;
                a_next       = i_reg;
                b_next       = (ip1 == n_reg) ? '0 : ip1[AW-1:0];
                ret_next     = poe_pkg::RET_CUR;
                state_next   = poe_pkg::B_RDA;
            end
            poe_pkg::B_CUR_DONE:
            begin
                cur_ok_next = uok_reg;
                cur_ux_next = ux_reg;
                cur_uy_next = uy_reg;
                out_x_next  = pa_x_reg;
                out_y_next  = pa_y_reg;
                st_next     = poe_pkg::STATUS_DEGEN;
                if (uok_reg && prev_ok_reg)
                begin
                    // Miter direction is the perpendicular of the summed unit edges.
                    vin_x_next = 26'(vsum_y);
                    vin_y_next = 26'(-vsum_x);
                    ret_next   = poe_pkg::RET_O;
                    state_next = poe_pkg::B_U_START;
                end
                else
                begin
                    state_next = poe_pkg::B_EMIT;
                end
            end
            poe_pkg::B_O_DONE:
            begin
                ox_next = ux_reg;
                oy_next = uy_reg;
                state_next = uok_reg ? poe_pkg::B_DOT1 : poe_pkg::B_EMIT;
            end
            poe_pkg::B_DOT1:
            begin
                dot_next   = 35'(dprod);
                state_next = poe_pkg::B_DOT2;
            end
            poe_pkg::B_DOT2:
            begin
                dot_next   = dot_reg - 35'(dprod);
                state_next = poe_pkg::B_OFS_X;
            end
            poe_pkg::B_OFS_X:
            begin
                if (!launched_reg)
                begin
                    if (dot_reg == '0)
                    begin
                        state_next = poe_pkg::B_EMIT;
                    end
                    else
                    begin
                        div_start     = 1'b1;
                        launched_next = 1'b1;
                    end
                end
                else if (div_done)
                begin
                    launched_next = 1'b0;
                    out_x_next    = poe_pkg::sat24(sum_val);
                    state_next    = poe_pkg::B_OFS_Y;
                end
            end
            poe_pkg::B_OFS_Y:
            begin
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (div_done)
                begin
                    launched_next = 1'b0;
                    out_y_next    = poe_pkg::sat24(sum_val);
                    st_next       = poe_pkg::STATUS_OK;
                    state_next    = poe_pkg::B_EMIT;
                end
            end
            poe_pkg::B_EMIT:
            begin
                if (!res_full)
                begin
                    res_push     = 1'b1;
                    prev_ok_next = cur_ok_reg;
                    prev_ux_next = cur_ux_reg;
                    prev_uy_next = cur_uy_reg;
                    if (is_last)
                    begin
                        done       = 1'b1;
                        state_next = poe_pkg::B_IDLE;
                    end
                    else
                    begin
                        i_next     = ip1[AW-1:0];
                        a_next     = ip1[AW-1:0];
                        b_next     = (ip2 == n_reg) ? '0 : ip2[AW-1:0];
                        ret_next   = poe_pkg::RET_CUR;
                        state_next = poe_pkg::B_RDA;
                    end
                end
            end
            default:
            begin
                state_next = poe_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= poe_pkg::B_IDLE;
            ret_reg      <= poe_pkg::RET_PREV;
            launched_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            launched_reg <= launched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        ovf_reg     <= ovf_next;
        i_reg       <= i_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        pa_x_reg    <= pa_x_next;
        pa_y_reg    <= pa_y_next;
        vin_x_reg   <= vin_x_next;
        vin_y_reg   <= vin_y_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        sq_reg      <= sq_next;
        m_reg       <= m_next;
        qx_reg      <= qx_next;
        uok_reg     <= uok_next;
        ux_reg      <= ux_next;
        uy_reg      <= uy_next;
        prev_ok_reg <= prev_ok_next;
        prev_ux_reg <= prev_ux_next;
        prev_uy_reg <= prev_uy_next;
        cur_ok_reg  <= cur_ok_next;
        cur_ux_reg  <= cur_ux_next;
        cur_uy_reg  <= cur_uy_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        dot_reg     <= dot_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        st_reg      <= st_next;
    end

endmodule

`default_nettype wire

### design/polygon_offset_enlarge_top.sv
// A vertex request is accepted whenever full is low while a polygon loads. After the last
// vertex each result takes two vector normalizations (doubling steps, a 26-step square
// root and two 48-step divisions each) and two 48-step offset divisions, all on one
// shared square root and divider. The first result of a polygon adds a normalization for
// the closing edge, and the input stays full until the last result is queued. Reset
// (rst_n, asynchronous) empties the queues and store count, sets distance 4.
`default_nettype none

module polygon_offset_enlarge_top #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic signed [poe_pkg::COORD_W-1:0]  point_x,
    input  wire logic signed [poe_pkg::COORD_W-1:0]  point_y,
    input  wire logic                                last_point,
    input  wire logic                                pop,
    output logic                                     empty,
    output logic signed [poe_pkg::COORD_W-1:0]       out_x,
    output logic signed [poe_pkg::COORD_W-1:0]       out_y,
    output logic                                     last_out,
    output logic [1:0]                               status,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [poe_pkg::DIST_W-1:0]          offset_distance
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int RW = $bits(poe_pkg::poe_result_t);

    logic [poe_pkg::DIST_W-1:0] dist_reg, dist_next;

    logic                  job_push, job_pop, job_full, job_empty;
    logic [CW:0]           job_in, job_out;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [47:0]           ram_wdata, ram_rdata;
    logic                  res_push, res_full;
    poe_pkg::poe_result_t  res_in, res_out;
    logic [RW-1:0]         res_out_bits;
    logic                  back_done;

    always_comb
    begin
        cfg_ready = 1'b1;
        dist_next = (cfg_valid && cfg_ready) ? offset_distance : dist_reg;
        res_out   = poe_pkg::poe_result_t'(res_out_bits);
        out_x     = res_out.out_x;
        out_y     = res_out.out_y;
        last_out  = res_out.last_out;
        status    = res_out.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= 8'd4;
        end
        else
        begin
            dist_reg <= dist_next;
        end
    end

    poe_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (last_point),
        .full       (full),
        .job_full   (job_full),
        .job_push   (job_push),
        .job_data   (job_in),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .done       (back_done)
    );

    poe_ram #(.WIDTH(48), .DEPTH(MAX_POINTS)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    poe_fifo #(.WIDTH(CW + 1), .DEPTH(2)) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (job_push),
        .din   (job_in),
        .full  (job_full),
        .rd    (job_pop),
        .dout  (job_out),
        .empty (job_empty)
    );

    poe_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_empty       (job_empty),
        .job_data        (job_out),
        .job_pop         (job_pop),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata),
        .offset_distance (dist_reg),
        .res_full        (res_full),
        .res_push        (res_push),
        .res_data        (res_in),
        .done            (back_done)
    );

    poe_fifo #(.WIDTH(RW), .DEPTH(2)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_push),
        .din   (res_in),
        .full  (res_full),
        .rd    (pop),
        .dout  (res_out_bits),
        .empty (empty)
    );

endmodule

`default_nettype wire

### design/poe_checker.sv
// Port-level checker for the polygon offset block, bound to the top level.
// Depends on poe_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module poe_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               push,
    input wire logic                               full,
    input wire logic                               last_point,
    input wire logic                               pop,
    input wire logic                               empty,
    input wire logic signed [poe_pkg::COORD_W-1:0] out_x,
    input wire logic signed [poe_pkg::COORD_W-1:0] out_y,
    input wire logic [1:0]                         status
);

    // A request that closes a polygon blocks the input until its results are computed.
    `POE_ASSERT_NEXT(a_block_after_last, push && !full && last_point, full)

    `POE_ASSERT_NOW(a_status_code, !empty, status <= poe_pkg::STATUS_OVERFLOW)

    `POE_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty && $stable(out_x) && $stable(out_y) && $stable(status))

endmodule

bind polygon_offset_enlarge_top poe_checker u_poe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .last_point (last_point),
    .pop        (pop),
    .empty      (empty),
    .out_x      (out_x),
    .out_y      (out_y),
    .status     (status)
);

`default_nettype wire
